FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a given clock, disabled while the given reset is low.
`define ASSERT_CLK_RST(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Same check on the usual clk / rst_n pair.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK_RST(label, clk, rst_n, prop, msg)

`endif

FILE: hw/rtl/pfd_pkg.sv
package pfd_pkg;

  // Fixed-point format and widths
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ERR_W     = DATA_W + 1;
  localparam int DIFFS_W   = ERR_W + 1;
  localparam int MUL_W     = ERR_W;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SH_W      = PROD_W - FRAC_BITS;
  localparam int WIDE_W    = PROD_W + 2;
  localparam int COEF_W    = 31;
  localparam int DT_W      = 17;
  localparam int MASK_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 4;

  // Enable mask bit positions
  localparam int EN_SETPOINT = 0;
  localparam int EN_MEASURED = 1;
  localparam int EN_DRIVE    = 2;

  // Reset values of the limit and enable registers
  localparam logic [COEF_W-1:0] INTEG_LIMIT_RST = '1;
  localparam logic [MASK_W-1:0] ENABLE_RST      = '1;

  // Arithmetic constants
  localparam logic signed [DATA_W-1:0] INTEG_THRESH = DATA_W'((1 << FRAC_BITS) / 1000);
  localparam logic signed [WIDE_W-1:0] ONE_W        = WIDE_W'(1) << FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] WMAX         = WIDE_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] WMIN         = -WMAX - WIDE_W'(1);
  localparam logic signed [DIFFS_W-1:0] DIFF_LIM    =
    DIFFS_W'({1'b0, {DATA_W{1'b1}}});

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_FILTER_COEF   = 3'd3,
    REG_INTEG_LIMIT   = 3'd4,
    REG_SAMPLE_PERIOD = 3'd5,
    REG_ENABLE_MASK   = 3'd6
  } cfg_reg_t;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    SA_KI, SA_KD, SA_N, SA_KP, SA_KIDT, SA_KDN, SA_FAC
  } sel_a_t;

  typedef enum logic [2:0] {
    SB_DT, SB_N, SB_ERR, SB_DIFF, SB_LDERIV
  } sel_b_t;

  // Write-back of the previous product
  typedef enum logic [3:0] {
    WB_NONE, WB_KIDT, WB_KDN, WB_FAC, WB_P, WB_P_CLR, WB_INTEG, WB_DK, WB_D, WB_OUT
  } wb_t;

  typedef enum logic [1:0] {
    J_NONE, J_ALWAYS, J_INTEG_OFF
  } jmp_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    sel_a_t sel_a;
    sel_b_t sel_b;
    wb_t    wb;
    jmp_t   jmp;
    step_t  target;
    logic   ld_diff;
    logic   done;
  } ctrl_word_t;

  // Microprogram addresses
  localparam step_t ST_KIDT  = 4'd0;
  localparam step_t ST_KDN   = 4'd1;
  localparam step_t ST_NDT   = 4'd2;
  localparam step_t ST_PROP  = 4'd3;
  localparam step_t ST_INTEG = 4'd4;
  localparam step_t ST_DIFF  = 4'd5;
  localparam step_t ST_FILT  = 4'd6;
  localparam step_t ST_DSUM  = 4'd7;
  localparam step_t ST_OUT   = 4'd8;
  localparam step_t ST_NOINT = 4'd9;

  // Saturate a wide signed value to DATA_W bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    priority if (x > WMAX) begin
      r = DATA_W'(WMAX);
    end else if (x < WMIN) begin
      r = DATA_W'(WMIN);
    end else begin
      r = DATA_W'(x);
    end
    return r;
  endfunction

  // Control store: most steps multiply and write back the product of the step before
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    w = '{sel_a: SA_KI, sel_b: SB_DT, wb: WB_NONE, jmp: J_NONE,
          target: ST_KIDT, ld_diff: 1'b0, done: 1'b0};
    unique case (step)
      ST_KIDT: begin
        w.sel_a = SA_KI;   w.sel_b = SB_DT;  w.ld_diff = 1'b1;
      end
      ST_KDN: begin
        w.sel_a = SA_KD;   w.sel_b = SB_N;   w.wb = WB_KIDT;
      end
      ST_NDT: begin
        w.sel_a = SA_N;    w.sel_b = SB_DT;  w.wb = WB_KDN;
      end
      ST_PROP: begin
        w.sel_a = SA_KP;   w.sel_b = SB_ERR; w.wb = WB_FAC;
        w.jmp = J_INTEG_OFF; w.target = ST_NOINT;
      end
      ST_INTEG: begin
        w.sel_a = SA_KIDT; w.sel_b = SB_ERR; w.wb = WB_P;
      end
      ST_DIFF: begin
        w.sel_a = SA_KDN;  w.sel_b = SB_DIFF; w.wb = WB_INTEG;
      end
      ST_FILT: begin
        w.sel_a = SA_FAC;  w.sel_b = SB_LDERIV; w.wb = WB_DK;
      end
      ST_DSUM: begin
        w.wb = WB_D;
      end
      ST_OUT: begin
        w.wb = WB_OUT;     w.done = 1'b1;
      end
      ST_NOINT: begin
        w.sel_a = SA_KDN;  w.sel_b = SB_DIFF; w.wb = WB_P_CLR;
        w.jmp = J_ALWAYS;  w.target = ST_FILT;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/pfd_in_if.sv
interface pfd_in_if;
  import pfd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

FILE: hw/rtl/pfd_out_if.sv
interface pfd_out_if;
  import pfd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

FILE: hw/rtl/pid_filtered_derivative.sv
// Parallel PID controller with a filtered derivative, Q16.16 fixed point.
// in_chan carries one word per control period (setpoint, measured); out_chan
// returns one drive word for each. Both use valid/ready, a word moving on a
// clock edge with both high. Gains, filter coefficient, integrator limit,
// sample period and enable bits are written on cfg_we / cfg_idx / cfg_wdata;
// the user must do so only while the controller is idle; the block does not enforce it.
// Datapath: one shared 33x33 multiplier, driven by a small microprogram, does
// seven products per word (six when the integrator is switched off).
// in_chan.ready is low while the program runs, so a new word is taken only
// once the program for the last one has finished.
// The output register lets the next word be accepted while a drive word still
// waits; if the receiver stalls, the program holds on its final step until the
// register frees up, and no word is lost.
// Reset (rst_n low at a clock edge) clears all controller state, sets the
// integrator limit to full scale and all enable bits, and empties the output.
// in_chan.ready stays low while rst_n is low.
`include "assert_macros.svh"

module pid_filtered_derivative (
  input  logic                           clk,
  input  logic                           rst_n,
  pfd_in_if.sink                         in_chan,
  pfd_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pfd_pkg::DATA_W-1:0]     cfg_wdata
);
  import pfd_pkg::*;

  // Configuration registers
  logic signed [DATA_W-1:0] prop_gain_r;
  logic signed [DATA_W-1:0] integ_gain_r;
  logic signed [DATA_W-1:0] deriv_gain_r;
  logic [COEF_W-1:0]        filter_coef_r;
  logic [COEF_W-1:0]        integ_limit_r;
  logic [DT_W-1:0]          sample_period_r;
  logic [MASK_W-1:0]        enable_mask_r;

  // Controller state
  logic signed [DATA_W-1:0] held_sp_r;
  logic signed [DATA_W-1:0] held_ms_r;
  logic signed [DATA_W-1:0] integ_acc_r;
  logic signed [ERR_W-1:0]  last_error_r;
  logic signed [DATA_W-1:0] last_deriv_r;

  // Sequencer
  logic       busy_r, busy_nxt;
  step_t      step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  ctrl_word_t cw;
  logic       out_free, exec, integ_off, jump_take, in_accept;

  // Datapath
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ERR_W-1:0]   diff_r, diff_nxt;
  logic signed [DIFFS_W-1:0] dsum;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [SH_W-1:0]    prod_sh;
  logic signed [WIDE_W-1:0]  sh_w, isum, ilim, nlim;
  logic signed [DATA_W-1:0]  kidt_r, kdn_r, fac_r;
  logic signed [SH_W-1:0]    p_r, dk_r;
  logic signed [DATA_W-1:0]  sp_nxt, ms_nxt, integ_nxt, d_nxt, u_nxt, fac_nxt, kidt_nxt;
  logic signed [DATA_W-1:0]  out_drive_r;

  // Control word and handshake decode
  assign cw        = ucode(step_r);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign exec      = busy_r && (!cw.done || out_free);
  assign integ_off = integ_gain_r <= INTEG_THRESH;
  assign jump_take = (cw.jmp == J_ALWAYS) || ((cw.jmp == J_INTEG_OFF) && integ_off);
  assign in_accept = in_chan.valid && in_chan.ready;

  assign in_chan.ready  = !busy_r && rst_n;
  assign out_chan.valid = out_valid_r;
  assign out_chan.drive = out_drive_r;

  // Input hold and error
  always_comb begin
    sp_nxt  = enable_mask_r[EN_SETPOINT] ? in_chan.setpoint : held_sp_r;
    ms_nxt  = enable_mask_r[EN_MEASURED] ? in_chan.measured : held_ms_r;
    err_nxt = ERR_W'(sp_nxt) - ERR_W'(ms_nxt);
  end

  // Error difference, clamped to +-(2^32 - 1)
  always_comb begin
    dsum = DIFFS_W'(err_r) - DIFFS_W'(last_error_r);
    priority if (dsum > DIFF_LIM) begin
      diff_nxt = ERR_W'(DIFF_LIM);
    end else if (dsum < -DIFF_LIM) begin
      diff_nxt = ERR_W'(-DIFF_LIM);
    end else begin
      diff_nxt = ERR_W'(dsum);
    end
  end

  // Multiplier operand muxes
  always_comb begin
    unique case (cw.sel_a)
      SA_KI:   mul_a = MUL_W'(integ_gain_r);
      SA_KD:   mul_a = MUL_W'(deriv_gain_r);
      SA_N:    mul_a = MUL_W'(filter_coef_r);
      SA_KP:   mul_a = MUL_W'(prop_gain_r);
      SA_KIDT: mul_a = MUL_W'(kidt_r);
      SA_KDN:  mul_a = MUL_W'(kdn_r);
      SA_FAC:  mul_a = MUL_W'(fac_r);
      default: mul_a = '0;
    endcase
    unique case (cw.sel_b)
      SB_DT:     mul_b = MUL_W'(sample_period_r);
      SB_N:      mul_b = MUL_W'(filter_coef_r);
      SB_ERR:    mul_b = err_r;
      SB_DIFF:   mul_b = diff_r;
      SB_LDERIV: mul_b = MUL_W'(last_deriv_r);
      default:   mul_b = '0;
    endcase
  end

  // Write-back arithmetic on the registered product (floor shift)
  always_comb begin
    prod_sh  = SH_W'(prod_r >>> FRAC_BITS);
    sh_w     = WIDE_W'(prod_sh);
    kidt_nxt = sat32(sh_w);
    fac_nxt  = sat32(ONE_W - sh_w);
    d_nxt    = sat32(WIDE_W'(dk_r) + sh_w);
    u_nxt    = sat32(WIDE_W'(p_r) + WIDE_W'(integ_acc_r) + WIDE_W'(last_deriv_r));
    isum     = WIDE_W'(integ_acc_r) + sh_w;
    ilim     = WIDE_W'(integ_limit_r);
    nlim     = -ilim;
    priority if (isum < nlim) begin
      integ_nxt = DATA_W'(nlim);
    end else if (isum > ilim) begin
      integ_nxt = DATA_W'(ilim);
    end else begin
      integ_nxt = DATA_W'(isum);
    end
  end

  // Sequencer next state
  always_comb begin
    step_nxt      = step_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_chan.ready ? 1'b0 : out_valid_r;
    priority if (in_accept) begin
      step_nxt = ST_KIDT;
      busy_nxt = 1'b1;
    end else if (exec) begin
      priority if (cw.done) begin
        step_nxt = ST_KIDT;
        busy_nxt = 1'b0;
      end else if (jump_take) begin
        step_nxt = cw.target;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
    if (exec && cw.wb == WB_OUT) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control, configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      step_r          <= ST_KIDT;
      out_valid_r     <= 1'b0;
      prop_gain_r     <= '0;
      integ_gain_r    <= '0;
      deriv_gain_r    <= '0;
      filter_coef_r   <= '0;
      integ_limit_r   <= INTEG_LIMIT_RST;
      sample_period_r <= '0;
      enable_mask_r   <= ENABLE_RST;
      held_sp_r       <= '0;
      held_ms_r       <= '0;
      integ_acc_r     <= '0;
      last_error_r    <= '0;
      last_deriv_r    <= '0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;

      // register writes
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_PROP_GAIN:     prop_gain_r     <= cfg_wdata;
          REG_INTEG_GAIN:    integ_gain_r    <= cfg_wdata;
          REG_DERIV_GAIN:    deriv_gain_r    <= cfg_wdata;
          REG_FILTER_COEF:   filter_coef_r   <= cfg_wdata[COEF_W-1:0];
          REG_INTEG_LIMIT:   integ_limit_r   <= cfg_wdata[COEF_W-1:0];
          REG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata[DT_W-1:0];
          REG_ENABLE_MASK:   enable_mask_r   <= cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end

      // held inputs
      if (in_accept) begin
        held_sp_r <= sp_nxt;
        held_ms_r <= ms_nxt;
      end

      // integrator and derivative memory
      if (exec) begin
        unique case (cw.wb)
          WB_INTEG: integ_acc_r <= integ_nxt;
          WB_P_CLR: integ_acc_r <= '0;
          WB_D: begin
            last_deriv_r <= d_nxt;
            last_error_r <= err_r;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      err_r <= err_nxt;
    end
    if (exec) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (cw.ld_diff) begin
        diff_r <= diff_nxt;
      end
      unique case (cw.wb)
        WB_KIDT:  kidt_r <= kidt_nxt;
        WB_KDN:   kdn_r  <= kidt_nxt;
        WB_FAC:   fac_r  <= fac_nxt;
        WB_P:     p_r    <= prod_sh;
        WB_P_CLR: p_r    <= prod_sh;
        WB_DK:    dk_r   <= prod_sh;
        WB_OUT:   out_drive_r <= enable_mask_r[EN_DRIVE] ? u_nxt : '0;
        default: ;
      endcase
    end
  end

  // Checks
  `ASSERT_STD(a_idle_at_start, !busy_r |-> (step_r == ST_KIDT), "idle with program running")
  `ASSERT_STD(a_accept_starts, in_accept |=> (busy_r && step_r == ST_KIDT), "word not started")
  `ASSERT_STD(a_stall_holds, (busy_r && cw.done && !out_free) |=> (busy_r && $stable(step_r)), "final step left under stall")
  `ASSERT_STD(a_result_lands, (exec && cw.wb == WB_OUT) |=> out_valid_r, "drive word dropped")

endmodule
